### hw/rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants for the text row splitter: byte class limits,
// row width bounds and the layout of one row record.
// ----------------------------------------------------------------------------
package trs_pkg;

  // field widths of the stream items
  localparam int unsigned TEXT_W   = 8;
  localparam int unsigned WIDTH_W  = 7;
  localparam int unsigned START_W  = 8;
  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned TOTAL_W  = 6;

  // packed payload widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned M_PAD_W  = M_DATA_W - START_W - LENGTH_W - TOTAL_W;

  // defaults for the top level parameters
  localparam int unsigned MAX_ROWS_DEF = 32;
  localparam int unsigned MAX_POS_DEF  = 255;

  // byte classes: below CTRL_LIMIT is a control byte, above ASCII_TOP a glyph lead
  localparam logic [TEXT_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [TEXT_W-1:0] ASCII_TOP  = 8'h7F;

  // row width bounds and reset value
  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 7'd2;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd20;

  // one row record as it leaves the block
  typedef struct packed {
    logic [TOTAL_W-1:0]  row_total;
    logic [LENGTH_W-1:0] row_length;
    logic [START_W-1:0]  row_start;
    logic                done_res;
  } row_rec_t;

endpackage

### hw/rtl/text_row_splitter_core.sv
// ----------------------------------------------------------------------------
// text_row_splitter_core
// Splits a byte stream of text into display rows and emits one record per
// row (start position, byte count, running row total), with the final record
// of a text marked by tlast.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload
//   ----------+-----+-----------------------------------------------------
//   s_axis    | in  | tdata: text_byte; tlast: last_byte
//   m_axis    | out | tdata: row_start, row_length, row_total; tlast: done_res
//   cfg       | in  | cfg_wdata: row_width, written when cfg_we is high
//
// One byte is taken per cycle; its records are formed in the same cycle and
// held in a three-entry result buffer, so a byte that yields at most one
// record flows at one per cycle. A byte yielding more than one record holds
// the input while the buffer drains one record per cycle as long as m_tready
// is high. Synchronous reset clears the row state and the buffer and sets
// the row width to 20. A stall on m_axis stops input once the last buffered
// record is not being taken.
//
module text_row_splitter_core #(
  parameter int unsigned MAX_ROWS = trs_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_POS  = trs_pkg::MAX_POS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [trs_pkg::WIDTH_W-1:0]   cfg_wdata,   // row_width
  // text input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [trs_pkg::S_DATA_W-1:0]  s_tdata,     // [7:0] text_byte
  input  logic                          s_tlast,     // last_byte
  // row records
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [trs_pkg::M_DATA_W-1:0]  m_tdata,     // [7:0] row_start,
                                                     // [14:8] row_length,
                                                     // [20:15] row_total
  output logic                          m_tlast      // done_res
);

  import trs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_POS + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_POS);
  localparam logic [RW-1:0] ROW_LIMIT = RW'(MAX_ROWS);

  // row state
  logic [WIDTH_W-1:0] row_width;
  logic [WIDTH_W-1:0] fill_count, fill_count_next;
  logic               fill_over, fill_over_next;   // true count is above 64
  logic [PW-1:0]      current_start, current_start_next;
  logic [PW-1:0]      byte_position, byte_position_next;
  logic [RW-1:0]      rows_done, rows_done_next;
  logic               skip_trail, skip_trail_next;

  // result buffer
  row_rec_t     rbuf [3];
  logic [1:0]   rbuf_cnt;
  logic [1:0]   rbuf_rd;

  // step signals
  logic               in_fire, out_fire;
  logic [TEXT_W-1:0]  text_byte;
  logic [WIDTH_W-1:0] width_eff;
  logic [WIDTH_W:0]   fill_sum;
  logic [PW-1:0]      start_sel;
  logic               straddle, row_full, close_now;
  logic               k0_vld, k1_vld, k2_vld, k3_vld;
  row_rec_t           k0_rec, k1_rec, k2_rec, k3_rec;
  row_rec_t           e0_rec, e1_rec, e2_rec;
  logic [1:0]         res_cnt;

  assign text_byte = s_tdata[TEXT_W-1:0];
  assign in_fire   = s_tvalid & s_tready;
  assign out_fire  = m_tvalid & m_tready;

  // clamp the configured width to 2..64
  always_comb begin
    if (row_width < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (row_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = row_width;
    end
  end

  // per-byte row logic
  always_comb begin
    fill_count_next    = fill_count;
    fill_over_next     = fill_over;
    current_start_next = current_start;
    rows_done_next     = rows_done;
    skip_trail_next    = skip_trail;
    byte_position_next = (byte_position < POS_LIMIT) ? byte_position + 1'b1 : byte_position;
    start_sel          = current_start;
    straddle           = 1'b0;
    row_full           = 1'b0;
    close_now          = 1'b0;
    fill_sum           = '0;
    k0_vld             = 1'b0;
    k1_vld             = 1'b0;
    k0_rec             = '0;
    k1_rec             = '0;

    if (rows_done >= ROW_LIMIT) begin
      fill_count_next = '0;
      fill_over_next  = 1'b0;
    end else if (skip_trail) begin
      skip_trail_next = 1'b0;
    end else if (text_byte < CTRL_LIMIT) begin
      // control byte closes a non-empty row
      if (fill_over || fill_count != '0) begin
        k0_vld          = 1'b1;
        k0_rec          = '{row_total: TOTAL_W'(rows_done + 1'b1), row_length: fill_count,
                            row_start: START_W'(current_start), done_res: 1'b0};
        rows_done_next  = rows_done + 1'b1;
        fill_count_next = '0;
        fill_over_next  = 1'b0;
      end
    end else begin
      if (!fill_over && fill_count == '0) begin
        start_sel = byte_position;
      end
      current_start_next = start_sel;
      if (text_byte > ASCII_TOP) begin
        // glyph lead: close the row first if the glyph would straddle it
        straddle = !fill_over && (fill_count == width_eff - 1'b1);
        if (straddle) begin
          k0_vld             = 1'b1;
          k0_rec             = '{row_total: TOTAL_W'(rows_done + 1'b1), row_length: fill_count,
                                 row_start: START_W'(start_sel), done_res: 1'b0};
          rows_done_next     = rows_done + 1'b1;
          current_start_next = byte_position;
          row_full           = (rows_done_next >= ROW_LIMIT);
          fill_count_next    = '0;
          fill_over_next     = 1'b0;
        end
        if (!row_full) begin
          fill_sum        = {1'b0, fill_count_next} + (WIDTH_W+1)'(2);
          fill_count_next = fill_sum[WIDTH_W-1:0];
          fill_over_next  = fill_over_next | (fill_sum > {1'b0, WIDTH_MAX});
          skip_trail_next = 1'b1;
          close_now       = !fill_over_next && (fill_count_next == width_eff);
        end
      end else begin
        fill_sum        = {1'b0, fill_count} + (WIDTH_W+1)'(1);
        fill_count_next = fill_sum[WIDTH_W-1:0];
        fill_over_next  = fill_over | (fill_sum > {1'b0, WIDTH_MAX});
        close_now       = !fill_over_next && (fill_count_next == width_eff);
      end
      // row exactly full
      if (close_now) begin
        if (straddle) begin
          k1_vld = 1'b1;
          k1_rec = '{row_total: TOTAL_W'(rows_done_next + 1'b1), row_length: fill_count_next,
                     row_start: START_W'(current_start_next), done_res: 1'b0};
        end else begin
          k0_vld = 1'b1;
          k0_rec = '{row_total: TOTAL_W'(rows_done_next + 1'b1), row_length: fill_count_next,
                     row_start: START_W'(current_start_next), done_res: 1'b0};
        end
        rows_done_next  = rows_done_next + 1'b1;
        fill_count_next = '0;
        fill_over_next  = 1'b0;
      end
    end

    // end of text: flush the partial row, or give a done-only record
    k2_vld = s_tlast && (fill_over_next || fill_count_next != '0) && (rows_done_next < ROW_LIMIT);
    k2_rec = '{row_total: TOTAL_W'(rows_done_next + 1'b1), row_length: fill_count_next,
               row_start: START_W'(current_start_next), done_res: 1'b0};
    k3_vld = s_tlast && !k0_vld && !k1_vld && !k2_vld;
    k3_rec = '{row_total: TOTAL_W'(rows_done_next), row_length: '0,
               row_start: '0, done_res: 1'b0};
    if (s_tlast) begin
      fill_count_next    = '0;
      fill_over_next     = 1'b0;
      current_start_next = '0;
      byte_position_next = '0;
      rows_done_next     = '0;
      skip_trail_next    = 1'b0;
    end
  end

  // pack the records of this byte in order, done on the final one
  always_comb begin
    res_cnt = 2'(k0_vld) + 2'(k1_vld) + 2'(k2_vld) + 2'(k3_vld);
    e0_rec  = k0_vld ? k0_rec : (k2_vld ? k2_rec : k3_rec);
    e1_rec  = k1_vld ? k1_rec : k2_rec;
    e2_rec  = k2_rec;
    e0_rec.done_res = s_tlast && (res_cnt == 2'd1);
    e1_rec.done_res = s_tlast && (res_cnt == 2'd2);
    e2_rec.done_res = s_tlast && (res_cnt == 2'd3);
  end

  // input is taken once the buffer holds at most the record now leaving
  assign s_tready = (rbuf_cnt == 2'd0) || (rbuf_cnt == 2'd1 && m_tready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // row state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      fill_over     <= 1'b0;
      current_start <= '0;
      byte_position <= '0;
      rows_done     <= '0;
      skip_trail    <= 1'b0;
    end else if (in_fire) begin
      fill_count    <= fill_count_next;
      fill_over     <= fill_over_next;
      current_start <= current_start_next;
      byte_position <= byte_position_next;
      rows_done     <= rows_done_next;
      skip_trail    <= skip_trail_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      rbuf_cnt <= '0;
      rbuf_rd  <= '0;
    end else if (in_fire) begin
      rbuf_cnt <= res_cnt;
      rbuf_rd  <= '0;
    end else if (out_fire) begin
      rbuf_cnt <= rbuf_cnt - 1'b1;
      rbuf_rd  <= rbuf_rd + 1'b1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rbuf[0] <= e0_rec;
      rbuf[1] <= e1_rec;
      rbuf[2] <= e2_rec;
    end
  end

  // output transaction
  assign m_tvalid = (rbuf_cnt != 2'd0);
  assign m_tdata  = {{M_PAD_W{1'b0}}, rbuf[rbuf_rd].row_total,
                     rbuf[rbuf_rd].row_length, rbuf[rbuf_rd].row_start};
  assign m_tlast  = rbuf[rbuf_rd].done_res;

`ifndef ASSERT_OFF
  // read pointer never runs past the buffered records
  a_rbuf_bound: assert property (@(posedge clk) disable iff (rst)
    (3'(rbuf_rd) + 3'(rbuf_cnt)) <= 3'd3)
    else $error("result buffer pointer out of range");

  // input is only taken when at most one record is pending
  a_ready_cnt: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (rbuf_cnt <= 2'd1))
    else $error("input taken with records pending");

  // the final byte of a text always yields a record
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("no record after final byte");

  // the done record is the last one in the buffer
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (rbuf_cnt == 2'd1))
    else $error("done record not last");
`endif

endmodule
